// ----- hdl/kcs_pkg.sv -----
// Shared types, constants and codes of the keyframe curve sampler.
`timescale 1ns / 1ps
package kcs_pkg;

  localparam int unsigned DEFAULT_MAX_KEYS = 16;
  localparam logic [31:0] ONE_Q            = 32'h0001_0000;
  localparam logic [31:0] HALF_Q           = 32'h0000_8000;
  localparam logic [31:0] RANGE_RESET      = 32'h0001_0000;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_AREA   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic REG_CURVE_RANGE = 1'b0;
  localparam logic REG_KEY_COUNT   = 1'b1;

  typedef enum logic [5:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_EV_ZERO,
    OP_EV_MUL,
    OP_EV_TM,
    OP_SCAN_RD,
    OP_SCAN_CHK,
    OP_RD_K,
    OP_LATCH_K,
    OP_LATCH_R,
    OP_DIV_F,
    OP_DIV_STEP,
    OP_MUL_V,
    OP_ADD_V,
    OP_ADD_S,
    OP_MUL_RND,
    OP_EV_FIN,
    OP_AR_T_END,
    OP_AR_RD,
    OP_AR_DIV,
    OP_AR_T,
    OP_SG_L,
    OP_SG_R,
    OP_SG_RV,
    OP_SG_MUL_SUM,
    OP_SG_ADD_SUM,
    OP_SG_MUL_POS,
    OP_SG_DIV,
    OP_SG_MUL_Q,
    OP_SG_ADD_Q,
    OP_AR_NEXT,
    OP_OUT_EV,
    OP_OUT_AREA,
    OP_OUT_ZERO
  } dp_op_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_EV_MUL,
    ST_EV_TM,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_RD_K,
    ST_LATCH_K,
    ST_LATCH_R,
    ST_CHK_SPAN,
    ST_DIVF,
    ST_ADD_V,
    ST_ADD_S,
    ST_MUL_RND,
    ST_EV_FIN,
    ST_AR_LOOP,
    ST_AR_DIV0,
    ST_AR_DIV,
    ST_SEG,
    ST_SG_R,
    ST_SG_RV,
    ST_SG_CLS,
    ST_SG_ADD_SUM,
    ST_SG_DIV0,
    ST_SG_DIV,
    ST_SG_ADD_Q,
    ST_AR_NEXT,
    ST_OUT_EV,
    ST_OUT_AREA,
    ST_OUT_ZERO
  } ctl_state_t;

  typedef enum logic [1:0] {
    RET_SAMPLE,
    RET_L,
    RET_R
  } ret_t;

  typedef struct packed {
    logic n_zero;
    logic r_lt_n;
    logic scan_hit;
    logic interp;
    logic span_pos;
    logic div_done;
    logic range_zero;
    logic kk_lt_n;
    logic t_le_prev;
    logic t_ge_end;
    logic both_nonneg;
    logic both_nonpos;
  } dp_stat_t;

endpackage

// ----- hdl/kcs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/kcs_ctrl.sv -----
// Sequencer for load, sample and area words of the curve sampler.
`timescale 1ns / 1ps
module kcs_ctrl
  import kcs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_command,
  input  dp_stat_t   stat,
  output dp_op_t     op,
  output logic       busy
);

  ctl_state_t state_r, state_nxt;
  ret_t       ret_r, ret_nxt;
  ctl_state_t ret_state;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= RET_SAMPLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    unique case (ret_r)
      RET_L:   ret_state = ST_SG_R;
      RET_R:   ret_state = ST_SG_RV;
      default: ret_state = ST_OUT_EV;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    op        = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op = OP_ACCEPT;
          unique case (in_command)
            CMD_SAMPLE: begin
              ret_nxt   = RET_SAMPLE;
              state_nxt = ST_EV_MUL;
            end
            CMD_AREA: state_nxt = ST_AR_LOOP;
            default:  state_nxt = ST_OUT_ZERO;
          endcase
        end
      end
      ST_EV_MUL: begin
        if (stat.n_zero) begin
          op        = OP_EV_ZERO;
          state_nxt = ret_state;
        end else begin
          op        = OP_EV_MUL;
          state_nxt = ST_EV_TM;
        end
      end
      ST_EV_TM: begin
        op        = OP_EV_TM;
        state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (stat.r_lt_n) begin
          op        = OP_SCAN_RD;
          state_nxt = ST_SCAN_CHK;
        end else begin
          state_nxt = ST_RD_K;
        end
      end
      ST_SCAN_CHK: begin
        op        = OP_SCAN_CHK;
        state_nxt = stat.scan_hit ? ST_SCAN_RD : ST_RD_K;
      end
      ST_RD_K: begin
        op        = OP_RD_K;
        state_nxt = ST_LATCH_K;
      end
      ST_LATCH_K: begin
        op        = OP_LATCH_K;
        state_nxt = stat.interp ? ST_LATCH_R : ST_MUL_RND;
      end
      ST_LATCH_R: begin
        op        = OP_LATCH_R;
        state_nxt = ST_CHK_SPAN;
      end
      ST_CHK_SPAN: begin
        if (stat.span_pos) begin
          op        = OP_DIV_F;
          state_nxt = ST_DIVF;
        end else begin
          state_nxt = ST_MUL_RND;
        end
      end
      ST_DIVF: begin
        if (stat.div_done) begin
          op        = OP_MUL_V;
          state_nxt = ST_ADD_V;
        end else begin
          op = OP_DIV_STEP;
        end
      end
      ST_ADD_V: begin
        op        = OP_ADD_V;
        state_nxt = ST_ADD_S;
      end
      ST_ADD_S: begin
        op        = OP_ADD_S;
        state_nxt = ST_MUL_RND;
      end
      ST_MUL_RND: begin
        op        = OP_MUL_RND;
        state_nxt = ST_EV_FIN;
      end
      ST_EV_FIN: begin
        op        = OP_EV_FIN;
        state_nxt = ret_state;
      end
      ST_AR_LOOP: begin
        if (!stat.kk_lt_n || stat.range_zero) begin
          op        = OP_AR_T_END;
          state_nxt = ST_SEG;
        end else begin
          op        = OP_AR_RD;
          state_nxt = ST_AR_DIV0;
        end
      end
      ST_AR_DIV0: begin
        op        = OP_AR_DIV;
        state_nxt = ST_AR_DIV;
      end
      ST_AR_DIV: begin
        if (stat.div_done) begin
          op        = OP_AR_T;
          state_nxt = ST_SEG;
        end else begin
          op = OP_DIV_STEP;
        end
      end
      ST_SEG: begin
        if (stat.t_le_prev) begin
          state_nxt = ST_AR_NEXT;
        end else begin
          op        = OP_SG_L;
          ret_nxt   = RET_L;
          state_nxt = ST_EV_MUL;
        end
      end
      ST_SG_R: begin
        op        = OP_SG_R;
        ret_nxt   = RET_R;
        state_nxt = ST_EV_MUL;
      end
      ST_SG_RV: begin
        op        = OP_SG_RV;
        state_nxt = ST_SG_CLS;
      end
      ST_SG_CLS: begin
        if (stat.both_nonneg) begin
          op        = OP_SG_MUL_SUM;
          state_nxt = ST_SG_ADD_SUM;
        end else if (stat.both_nonpos) begin
          state_nxt = ST_AR_NEXT;
        end else begin
          op        = OP_SG_MUL_POS;
          state_nxt = ST_SG_DIV0;
        end
      end
      ST_SG_ADD_SUM: begin
        op        = OP_SG_ADD_SUM;
        state_nxt = ST_AR_NEXT;
      end
      ST_SG_DIV0: begin
        op        = OP_SG_DIV;
        state_nxt = ST_SG_DIV;
      end
      ST_SG_DIV: begin
        if (stat.div_done) begin
          op        = OP_SG_MUL_Q;
          state_nxt = ST_SG_ADD_Q;
        end else begin
          op = OP_DIV_STEP;
        end
      end
      ST_SG_ADD_Q: begin
        op        = OP_SG_ADD_Q;
        state_nxt = ST_AR_NEXT;
      end
      ST_AR_NEXT: begin
        op        = OP_AR_NEXT;
        state_nxt = stat.t_ge_end ? ST_OUT_AREA : ST_AR_LOOP;
      end
      ST_OUT_EV: begin
        op        = OP_OUT_EV;
        state_nxt = ST_IDLE;
      end
      ST_OUT_AREA: begin
        op        = OP_OUT_AREA;
        state_nxt = ST_IDLE;
      end
      ST_OUT_ZERO: begin
        op        = OP_OUT_ZERO;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- hdl/kcs_dpath.sv -----
// Datapath: key table, shared multiplier, radix-2 divider and result register.
`timescale 1ns / 1ps
module kcs_dpath
  import kcs_pkg::*;
#(
  parameter int unsigned MAX_KEYS = DEFAULT_MAX_KEYS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_op_t             op,
  output dp_stat_t           stat,
  input  logic [1:0]         in_command,
  input  logic [3:0]         in_key_index,
  input  logic [31:0]        in_key_time,
  input  logic signed [31:0] in_key_value,
  input  logic signed [31:0] in_key_spread,
  input  logic signed [31:0] in_phase,
  input  logic signed [31:0] in_random,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  output logic               out_valid,
  output logic signed [47:0] out_result
);

  localparam int unsigned KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned NW = $clog2(MAX_KEYS + 1);

  function automatic logic [16:0] unit_clamp(input logic signed [31:0] x);
    logic [16:0] y;
    if (x < 0) y = 17'd0;
    else if (x > $signed(ONE_Q)) y = ONE_Q[16:0];
    else y = x[16:0];
    return y;
  endfunction

  logic [31:0]        range_r;
  logic [4:0]         count_r;
  logic               out_valid_r;
  logic signed [47:0] out_result_r;

  logic [16:0]        ep_r, erd_r, end_r, prev_r, t_r, w_r;
  logic [31:0]        tm_r, tk_r, tr_r;
  logic signed [31:0] vk_r, sk_r, vr_r, sr_r;
  logic signed [33:0] val_r, spr_r;
  logic signed [35:0] ev_r, l_r, r_r;
  logic signed [47:0] area_r;
  logic signed [67:0] prod_r;
  logic [NW-1:0]      ri_r, kk_r;
  logic [33:0]        rem_r;
  logic [63:0]        dsh_r, quo_r;
  logic [32:0]        div_r;
  logic [6:0]         dcnt_r;

  logic [NW-1:0]      n_w;
  logic [KW-1:0]      raddr;
  logic [95:0]        rdata;
  logic [31:0]        rd_time;
  logic signed [31:0] rd_val, rd_spr;
  logic               ram_we;
  logic signed [33:0] ma, mb;
  logic [34:0]        rem2;
  logic               qbit;
  logic               l_gt;
  logic signed [35:0] pos36, diff36;

  assign n_w = (32'(count_r) > MAX_KEYS) ? NW'(MAX_KEYS) : NW'(count_r);

  assign ram_we = (op == OP_ACCEPT) && (in_command == CMD_LOAD) &&
                  (32'(in_key_index) < MAX_KEYS);

  always_comb begin
    unique case (op)
      OP_RD_K:  raddr = (ri_r == '0) ? '0 : KW'(ri_r - 1'b1);
      OP_AR_RD: raddr = KW'(kk_r);
      default:  raddr = KW'(ri_r);
    endcase
  end

  kcs_ram #(
    .WIDTH(96),
    .DEPTH(MAX_KEYS)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (KW'(in_key_index)),
    .wdata ({in_key_time, in_key_value, in_key_spread}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_time = rdata[95:64];
  assign rd_val  = rdata[63:32];
  assign rd_spr  = rdata[31:0];

  assign l_gt   = l_r > r_r;
  assign pos36  = l_gt ? l_r : r_r;
  assign diff36 = l_gt ? (l_r - r_r) : (r_r - l_r);

  always_comb begin
    unique case (op)
      OP_EV_MUL: begin
        ma = {17'd0, ep_r};
        mb = {2'd0, range_r};
      end
      OP_MUL_V: begin
        ma = 34'(vr_r) - 34'(vk_r);
        mb = {18'd0, quo_r[15:0]};
      end
      OP_ADD_V: begin
        ma = 34'(sr_r) - 34'(sk_r);
        mb = {18'd0, quo_r[15:0]};
      end
      OP_MUL_RND: begin
        ma = 34'(erd_r) - 34'(HALF_Q);
        mb = spr_r;
      end
      OP_SG_MUL_SUM: begin
        ma = 34'(l_r) + 34'(r_r);
        mb = {17'd0, w_r};
      end
      OP_SG_MUL_POS: begin
        ma = {2'd0, pos36[31:0]};
        mb = {2'd0, pos36[31:0]};
      end
      OP_SG_MUL_Q: begin
        ma = {2'd0, quo_r[31:0]};
        mb = {17'd0, w_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign rem2 = {rem_r, dsh_r[63]};
  assign qbit = rem2 >= {2'd0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r     <= RANGE_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CURVE_RANGE: range_r <= cfg_wdata;
          REG_KEY_COUNT:   count_r <= cfg_wdata[4:0];
          default:         range_r <= range_r;
        endcase
      end
      out_valid_r <= (op == OP_OUT_EV) || (op == OP_OUT_AREA) || (op == OP_OUT_ZERO);
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_ACCEPT: begin
        ep_r   <= unit_clamp(in_phase);
        erd_r  <= unit_clamp(in_random);
        end_r  <= unit_clamp(in_phase);
        prev_r <= '0;
        area_r <= '0;
        kk_r   <= '0;
      end
      OP_EV_ZERO: ev_r <= '0;
      OP_EV_MUL: begin
        prod_r <= ma * mb;
        ri_r   <= '0;
      end
      OP_EV_TM:    tm_r <= prod_r[47:16];
      OP_SCAN_RD:  ri_r <= ri_r;
      OP_SCAN_CHK: begin
        if (rd_time <= tm_r) ri_r <= ri_r + 1'b1;
      end
      OP_RD_K: tk_r <= tk_r;
      OP_LATCH_K: begin
        tk_r  <= rd_time;
        vk_r  <= rd_val;
        sk_r  <= rd_spr;
        val_r <= 34'(rd_val);
        spr_r <= 34'(rd_spr);
      end
      OP_LATCH_R: begin
        tr_r <= rd_time;
        vr_r <= rd_val;
        sr_r <= rd_spr;
      end
      OP_DIV_F: begin
        rem_r  <= {2'd0, tm_r - tk_r};
        dsh_r  <= '0;
        quo_r  <= '0;
        div_r  <= {1'b0, tr_r - tk_r};
        dcnt_r <= 7'd16;
      end
      OP_DIV_STEP: begin
        rem_r  <= qbit ? 34'(rem2 - {2'd0, div_r}) : rem2[33:0];
        dsh_r  <= {dsh_r[62:0], 1'b0};
        quo_r  <= {quo_r[62:0], qbit};
        dcnt_r <= dcnt_r - 1'b1;
      end
      OP_MUL_V: prod_r <= ma * mb;
      OP_ADD_V: begin
        val_r  <= 34'(vk_r) + prod_r[49:16];
        prod_r <= ma * mb;
      end
      OP_ADD_S:   spr_r  <= 34'(sk_r) + prod_r[49:16];
      OP_MUL_RND: prod_r <= ma * mb;
      OP_EV_FIN:  ev_r   <= 36'(val_r) + prod_r[51:16];
      OP_AR_T_END: t_r   <= end_r;
      OP_AR_RD:    kk_r  <= kk_r;
      OP_AR_DIV: begin
        rem_r  <= '0;
        dsh_r  <= {rd_time, 32'd0};
        quo_r  <= '0;
        div_r  <= {1'b0, range_r};
        dcnt_r <= 7'd48;
      end
      OP_AR_T: t_r <= (quo_r < 64'(end_r)) ? quo_r[16:0] : end_r;
      OP_SG_L: begin
        ep_r  <= prev_r;
        erd_r <= HALF_Q[16:0];
        w_r   <= t_r - prev_r;
      end
      OP_SG_R: begin
        l_r  <= ev_r;
        ep_r <= t_r;
      end
      OP_SG_RV:      r_r    <= ev_r;
      OP_SG_MUL_SUM: prod_r <= ma * mb;
      OP_SG_ADD_SUM: area_r <= area_r + prod_r[64:17];
      OP_SG_MUL_POS: prod_r <= ma * mb;
      OP_SG_DIV: begin
        rem_r  <= '0;
        dsh_r  <= prod_r[63:0];
        quo_r  <= '0;
        div_r  <= {diff36[31:0], 1'b0};
        dcnt_r <= 7'd64;
      end
      OP_SG_MUL_Q: prod_r <= ma * mb;
      OP_SG_ADD_Q: area_r <= area_r + prod_r[63:16];
      OP_AR_NEXT: begin
        prev_r <= t_r;
        kk_r   <= kk_r + 1'b1;
      end
      OP_OUT_EV:   out_result_r <= 48'(ev_r);
      OP_OUT_AREA: out_result_r <= area_r;
      OP_OUT_ZERO: out_result_r <= '0;
      default:     out_result_r <= out_result_r;
    endcase
  end

  always_comb begin
    stat.n_zero      = (n_w == '0);
    stat.r_lt_n      = (ri_r < n_w);
    stat.scan_hit    = (rd_time <= tm_r);
    stat.interp      = (ri_r != '0) && (ri_r != n_w);
    stat.span_pos    = (tr_r > tk_r);
    stat.div_done    = (dcnt_r == '0);
    stat.range_zero  = (range_r == '0);
    stat.kk_lt_n     = (kk_r < n_w);
    stat.t_le_prev   = (t_r <= prev_r);
    stat.t_ge_end    = (t_r >= end_r);
    stat.both_nonneg = !l_r[35] && !r_r[35];
    stat.both_nonpos = (l_r <= 0) && (r_r <= 0);
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

// ----- hdl/keyframe_curve_sampler_top.sv -----
// Top level of the keyframe curve sampler: controller, datapath, config port.
`timescale 1ns / 1ps
// One word at a time: start is taken while busy is low, and the result shows
// on out_result for one cycle with out_valid, in the first cycle that busy is
// low again; it cannot be held off. A load or unused code returns zero. A
// sample returns zero on an empty table; else it scans the keys in order for
// the first whose time exceeds the scaled phase, and when it finds one other
// than the first key, and that key's time is above the one before it, it
// interpolates between the two with the 16-step divider. An area word walks
// the key segments: per key a 48-step time division, and per segment two
// curve evaluations and possibly a 64-step division. The table has a single
// read port, and the multiplier and radix-2 divider are shared. No clearing
// pass after reset.
module keyframe_curve_sampler_top
  import kcs_pkg::*;
#(
  parameter int unsigned MAX_KEYS = DEFAULT_MAX_KEYS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [3:0]         in_key_index,
  input  logic [31:0]        in_key_time,
  input  logic signed [31:0] in_key_value,
  input  logic signed [31:0] in_key_spread,
  input  logic signed [31:0] in_phase,
  input  logic signed [31:0] in_random,
  output logic               out_valid,
  output logic signed [47:0] out_result,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  dp_op_t   op;
  dp_stat_t stat;

  kcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .op         (op),
    .busy       (busy)
  );

  kcs_dpath #(
    .MAX_KEYS(MAX_KEYS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .op            (op),
    .stat          (stat),
    .in_command    (in_command),
    .in_key_index  (in_key_index),
    .in_key_time   (in_key_time),
    .in_key_value  (in_key_value),
    .in_key_spread (in_key_spread),
    .in_phase      (in_phase),
    .in_random     (in_random),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .out_valid     (out_valid),
    .out_result    (out_result)
  );

endmodule

// ----- hdl/kcs_checker.sv -----
// Port-level checks on the curve sampler, bound to the top level.
`timescale 1ns / 1ps
module kcs_checker
  import kcs_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [1:0]         in_command,
  input logic               out_valid,
  input logic signed [47:0] out_result
);

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_LOAD)) |=> ##1 (out_valid && (out_result == '0)))
    else $error("load word did not return zero in two cycles");

endmodule

bind keyframe_curve_sampler_top kcs_checker u_kcs_checker (.*);
